// ===== rtl/hmf_pkg.sv =====
// Package for the homomorphic filter gain generator.
// Holds the channel payload types, register indexes and fixed constants.
// No dependencies.
package hmf_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_COLS     = 1024;
  localparam int TAYLOR_TERMS = 14;
  localparam int QUOT_BITS    = 35;
  localparam int SQUARINGS    = 4;

  localparam logic [6:0]  GAIN_LIMIT = 7'd100;
  localparam logic [10:0] ROWS_LIMIT = 11'(MAX_ROWS);
  localparam logic [10:0] COLS_LIMIT = 11'(MAX_COLS);
  localparam logic [4:0]  EXP_LIMIT  = 5'd12;

  typedef enum logic [2:0] {
    REG_GAIN_HIGH  = 3'd0,
    REG_GAIN_LOW   = 3'd1,
    REG_SHARPNESS  = 3'd2,
    REG_CUTOFF     = 3'd3,
    REG_PLANE_ROWS = 3'd4,
    REG_PLANE_COLS = 3'd5
  } hmf_reg_t;

  typedef struct packed {
    logic [9:0] row_index;
    logic [9:0] col_index;
  } hmf_in_t;

  typedef struct packed {
    logic [22:0] gain_value;
    logic        cutoff_zero;
  } hmf_out_t;

  typedef struct packed {
    logic big;
    logic d2_zero;
  } hmf_side_t;

endpackage

// ===== rtl/hmf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage: x = (num << 31) / den.
// Depends on hmf_pkg.
module hmf_div import hmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [27:0]          in_num,
  input  logic [13:0]          in_den,
  input  hmf_side_t            in_side,
  output logic                 out_valid,
  output logic [QUOT_BITS-1:0] out_quot,
  output hmf_side_t            out_side
);

  logic                 vld_a  [QUOT_BITS+1];
  logic [13:0]          rem_a  [QUOT_BITS+1];
  logic [13:0]          den_a  [QUOT_BITS+1];
  logic [3:0]           lo_a   [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quot_a [QUOT_BITS+1];
  hmf_side_t            side_a [QUOT_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a[0] <= 1'b0;
    end else if (en) begin
      vld_a[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_a[0]  <= in_side.big ? 14'd0 : in_num[17:4];
      den_a[0]  <= in_den;
      lo_a[0]   <= in_num[3:0];
      quot_a[0] <= '0;
      side_a[0] <= in_side;
    end
  end

  for (genvar g = 0; g < QUOT_BITS; g++) begin : g_stage
    localparam int BIT = QUOT_BITS - 1 - g;
    logic        nbit;
    logic [14:0] trial;
    logic        take;

    always_comb begin
      nbit  = (BIT >= 31) ? lo_a[g][(BIT >= 31) ? BIT - 31 : 0] : 1'b0;
      trial = {rem_a[g], nbit};
      take  = trial >= {1'b0, den_a[g]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_a[g+1] <= 1'b0;
      end else if (en) begin
        vld_a[g+1] <= vld_a[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[g+1]  <= take ? 14'(trial - {1'b0, den_a[g]}) : trial[13:0];
        den_a[g+1]  <= den_a[g];
        lo_a[g+1]   <= lo_a[g];
        quot_a[g+1] <= {quot_a[g][QUOT_BITS-2:0], take};
        side_a[g+1] <= side_a[g];
      end
    end
  end

  assign out_valid = vld_a[QUOT_BITS];
  assign out_quot  = quot_a[QUOT_BITS];
  assign out_side  = side_a[QUOT_BITS];

endmodule

// ===== rtl/hmf_exp.sv =====
// Pipelined exp(-x) in Q1.31: Taylor series on x/16, then four rounded squarings.
// Depends on hmf_pkg.
module hmf_exp import hmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [QUOT_BITS-1:0] in_x,
  input  hmf_side_t            in_side,
  output logic                 out_valid,
  output logic [31:0]          out_e,
  output hmf_side_t            out_side
);

  localparam logic [31:0] Q31_ONE = 32'h8000_0000;

  logic        vld_a  [TAYLOR_TERMS+1];
  logic [31:0] term_a [TAYLOR_TERMS+1];
  logic [30:0] a_a    [TAYLOR_TERMS+1];
  logic [33:0] even_a [TAYLOR_TERMS+1];
  logic [33:0] odd_a  [TAYLOR_TERMS+1];
  hmf_side_t   side_a [TAYLOR_TERMS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a[0] <= 1'b0;
    end else if (en) begin
      vld_a[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_a[0] <= Q31_ONE;
      a_a[0]    <= in_x[QUOT_BITS-1:4];
      even_a[0] <= 34'(Q31_ONE);
      odd_a[0]  <= '0;
      side_a[0] <= in_side;
    end
  end

  for (genvar g = 1; g <= TAYLOR_TERMS; g++) begin : g_term
    localparam int          K = g;
    localparam logic [32:0] M = 33'((64'd1 << 32) / K);

    logic        v1_r, v2_r;
    logic [62:0] prod_r;
    logic [30:0] a1_r, a2_r, p_r;
    logic [33:0] ev1_r, od1_r, ev2_r, od2_r;
    hmf_side_t   sd1_r, sd2_r;
    logic [63:0] qm_r;
    logic [30:0] q, q_fix;
    logic [31:0] qk, r;

    always_comb begin
      q     = qm_r[62:32];
      qk    = 32'(32'(q) * 32'(K));
      r     = {1'b0, p_r} - qk;
      q_fix = q + 31'(r >= 32'(K));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r       <= 1'b0;
        v2_r       <= 1'b0;
        vld_a[g]   <= 1'b0;
      end else if (en) begin
        v1_r       <= vld_a[g-1];
        v2_r       <= v1_r;
        vld_a[g]   <= v2_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod_r    <= 63'(term_a[g-1]) * 63'(a_a[g-1]);
        a1_r      <= a_a[g-1];
        ev1_r     <= even_a[g-1];
        od1_r     <= odd_a[g-1];
        sd1_r     <= side_a[g-1];

        p_r       <= prod_r[61:31];
        qm_r      <= 64'(prod_r[61:31]) * 64'(M);
        a2_r      <= a1_r;
        ev2_r     <= ev1_r;
        od2_r     <= od1_r;
        sd2_r     <= sd1_r;

        term_a[g] <= {1'b0, q_fix};
        a_a[g]    <= a2_r;
        even_a[g] <= (K % 2 == 0) ? ev2_r + 34'(q_fix) : ev2_r;
        odd_a[g]  <= (K % 2 == 1) ? od2_r + 34'(q_fix) : od2_r;
        side_a[g] <= sd2_r;
      end
    end
  end

  logic        sq_v  [SQUARINGS+1];
  logic [31:0] sq_e  [SQUARINGS+1];
  hmf_side_t   sq_sd [SQUARINGS+1];
  logic [33:0] diff;

  always_comb begin
    if (even_a[TAYLOR_TERMS] >= odd_a[TAYLOR_TERMS]) begin
      diff = even_a[TAYLOR_TERMS] - odd_a[TAYLOR_TERMS];
    end else begin
      diff = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= vld_a[TAYLOR_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_e[0]  <= (diff > 34'(Q31_ONE)) ? Q31_ONE : diff[31:0];
      sq_sd[0] <= side_a[TAYLOR_TERMS];
    end
  end

  for (genvar s = 0; s < SQUARINGS; s++) begin : g_sq
    logic [63:0] sq;

    assign sq = 64'(sq_e[s]) * 64'(sq_e[s]) + 64'(1) * 64'h4000_0000;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v[s+1] <= 1'b0;
      end else if (en) begin
        sq_v[s+1] <= sq_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_e[s+1]  <= sq[62:31];
        sq_sd[s+1] <= sq_sd[s];
      end
    end
  end

  assign out_valid = sq_v[SQUARINGS];
  assign out_e     = sq_e[SQUARINGS];
  assign out_side  = sq_sd[SQUARINGS];

endmodule

// ===== rtl/homomorphic_filter_mask_gen.sv =====
// Top level of the Gaussian homomorphic filter gain generator.
// Depends on hmf_pkg, hmf_div and hmf_exp.
//
//   channel  direction  payload     handshake
//   in_      input      hmf_in_t    in_valid / in_stall
//   out_     output     hmf_out_t   out_valid / out_stall
//   cfg_     input      6 regs      cfg_we, cfg_index, cfg_wdata
//
// One transaction enters per cycle unless a valid output is stalled. The pipeline holds
// four distance stages, the divider's entry register and 35 quotient stages, the exp
// entry register, three stages per Taylor term, five exp tail stages and the output.
// All stages advance together; a stall while the output is valid freezes the whole pipeline.
// Reset clears valid bits and restores the register defaults.
module homomorphic_filter_mask_gen import hmf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  hmf_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output hmf_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  logic [6:0]  gain_high_r, gain_low_r, sharpness_r, cutoff_r;
  logic [10:0] plane_rows_r, plane_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_high_r  <= '0;
      gain_low_r   <= '0;
      sharpness_r  <= '0;
      cutoff_r     <= '0;
      plane_rows_r <= ROWS_LIMIT;
      plane_cols_r <= COLS_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_HIGH:  gain_high_r  <= cfg_wdata[6:0];
        REG_GAIN_LOW:   gain_low_r   <= cfg_wdata[6:0];
        REG_SHARPNESS:  sharpness_r  <= cfg_wdata[6:0];
        REG_CUTOFF:     cutoff_r     <= cfg_wdata[6:0];
        REG_PLANE_ROWS: plane_rows_r <= cfg_wdata;
        REG_PLANE_COLS: plane_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [6:0]  gh, gl, sl, d0;
  logic [10:0] rows, cols;
  logic [9:0]  half_r, half_c;

  always_comb begin
    gh     = (gain_high_r > GAIN_LIMIT) ? GAIN_LIMIT : gain_high_r;
    gl     = (gain_low_r > GAIN_LIMIT) ? GAIN_LIMIT : gain_low_r;
    sl     = (sharpness_r > GAIN_LIMIT) ? GAIN_LIMIT : sharpness_r;
    d0     = (cutoff_r > GAIN_LIMIT) ? GAIN_LIMIT : cutoff_r;
    rows   = (plane_rows_r > ROWS_LIMIT) ? ROWS_LIMIT : plane_rows_r;
    cols   = (plane_cols_r > COLS_LIMIT) ? COLS_LIMIT : plane_cols_r;
    half_r = rows[10:1];
    half_c = cols[10:1];
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [9:0]  dr_r, dc_r;
  logic [20:0] d2_r;
  logic [27:0] num3_r, num4_r;
  logic [13:0] den3_r, den4_r;
  logic        d2z3_r;
  hmf_side_t   side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dr_r <= (in_data.row_index >= half_r) ? in_data.row_index - half_r
                                            : half_r - in_data.row_index;
      dc_r <= (in_data.col_index >= half_c) ? in_data.col_index - half_c
                                            : half_c - in_data.col_index;
      d2_r <= 21'(20'(dr_r) * 20'(dr_r)) + 21'(20'(dc_r) * 20'(dc_r));
      num3_r <= 28'(sl) * 28'(d2_r);
      den3_r <= 14'(d0) * 14'(d0);
      d2z3_r <= d2_r == '0;
      num4_r <= num3_r;
      den4_r <= den3_r;
      side4_r.d2_zero <= d2z3_r;
      side4_r.big     <= num3_r >= 28'(18'(EXP_LIMIT) * 18'(den3_r));
    end
  end

  logic                 dv;
  logic [QUOT_BITS-1:0] dq;
  hmf_side_t            dsd;

  hmf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v4_r),
    .in_num    (num4_r),
    .in_den    (den4_r),
    .in_side   (side4_r),
    .out_valid (dv),
    .out_quot  (dq),
    .out_side  (dsd)
  );

  logic        ev;
  logic [31:0] ee;
  hmf_side_t   esd;

  hmf_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (dv),
    .in_x      (dq),
    .in_side   (dsd),
    .out_valid (ev),
    .out_e     (ee),
    .out_side  (esd)
  );

  logic [32:0] e_rnd;
  logic [16:0] e16, comp;
  logic [6:0]  gdiff;
  logic [23:0] base, prod, gain;
  hmf_out_t    out_nxt;

  always_comb begin
    e_rnd = 33'(ee) + 33'h4000;
    e16   = esd.big ? 17'd0 : e_rnd[31:15];
    comp  = 17'h1_0000 - e16;
    gdiff = (gh >= gl) ? gh - gl : gl - gh;
    base  = {1'b0, gl, 16'd0};
    prod  = 24'(gdiff) * 24'(comp);
    if (d0 == '0) begin
      gain = {1'b0, (esd.d2_zero ? gl : gh), 16'd0};
    end else if (gh >= gl) begin
      gain = base + prod;
    end else begin
      gain = base - prod;
    end
    out_nxt.gain_value  = gain[22:0];
    out_nxt.cutoff_zero = d0 == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= out_nxt;
    end
  end

endmodule

// ===== tb/hmf_checker.sv =====
// Checker for the homomorphic filter gain generator: predicts each gain from the
// accepted coordinates and the register writes, and compares the results in order.
// Depends on hmf_pkg.
module hmf_checker import hmf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  hmf_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  hmf_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [6:0]  gain_high, gain_low, sharpness, cutoff;
  logic [10:0] plane_rows, plane_cols;
  hmf_out_t    gain_queue[$];

  function automatic logic [6:0] clamp100(logic [6:0] v);
    return (v > 7'd100) ? 7'd100 : v;
  endfunction

  function automatic logic [63:0] exp_neg(logic [63:0] x);
    logic [63:0] a, term, even, odd, e;
    a = x >> 4;
    term = 64'h8000_0000;
    even = 64'h8000_0000;
    odd = 0;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * a) >> 31) / k;
      if (k % 2 == 1) odd += term;
      else even += term;
    end
    e = (even >= odd) ? even - odd : 0;
    if (e > 64'h8000_0000) e = 64'h8000_0000;
    for (int k = 0; k < 4; k++) e = (e * e + (64'd1 << 30)) >> 31;
    return e;
  endfunction

  function automatic hmf_out_t predict_gain(hmf_in_t item);
    hmf_out_t res;
    logic [63:0] gh, gl, sl, d0, rows, cols, dr, dc, d2, num, den, e16, comp, gain;
    gh = clamp100(gain_high);
    gl = clamp100(gain_low);
    sl = clamp100(sharpness);
    d0 = clamp100(cutoff);
    rows = (plane_rows > 11'd1024) ? 1024 : plane_rows;
    cols = (plane_cols > 11'd1024) ? 1024 : plane_cols;
    dr = (item.row_index >= rows / 2) ? item.row_index - rows / 2 : rows / 2 - item.row_index;
    dc = (item.col_index >= cols / 2) ? item.col_index - cols / 2 : cols / 2 - item.col_index;
    d2 = dr * dr + dc * dc;
    res.cutoff_zero = (d0 == 0);
    if (d0 == 0) begin
      gain = ((d2 == 0) ? gl : gh) << 16;
    end else begin
      num = sl * d2;
      den = d0 * d0;
      e16 = 0;
      if (num < 12 * den) e16 = (exp_neg((num << 31) / den) + (64'd1 << 14)) >> 15;
      comp = 65536 - e16;
      if (gh >= gl) gain = (gl << 16) + (gh - gl) * comp;
      else gain = (gl << 16) - (gl - gh) * comp;
    end
    res.gain_value = gain[22:0];
    return res;
  endfunction

  assign pending = gain_queue.size();

  always @(posedge clk) begin
    hmf_out_t want;
    if (!rst_n) begin
      gain_high <= '0;
      gain_low <= '0;
      sharpness <= '0;
      cutoff <= '0;
      plane_rows <= 11'd1024;
      plane_cols <= 11'd1024;
      fail_count <= 0;
      gain_queue.delete();
    end else begin
      if (in_valid && !in_stall) gain_queue = {gain_queue, predict_gain(in_data)};
      if (out_valid && !out_stall) begin
        if (gain_queue.size() == 0) begin
          if (fail_count < 10) $display("Unexpected transaction: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = gain_queue.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("Mismatch: expected gain %0d flag %0d, got gain %0d flag %0d",
                       want.gain_value, want.cutoff_zero, out_data.gain_value,
                       out_data.cutoff_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        case (hmf_reg_t'(cfg_index))
          REG_GAIN_HIGH:  gain_high <= cfg_wdata[6:0];
          REG_GAIN_LOW:   gain_low <= cfg_wdata[6:0];
          REG_SHARPNESS:  sharpness <= cfg_wdata[6:0];
          REG_CUTOFF:     cutoff <= cfg_wdata[6:0];
          REG_PLANE_ROWS: plane_rows <= cfg_wdata;
          REG_PLANE_COLS: plane_cols <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/homomorphic_filter_mask_gen_tb.sv =====
// Top of the testbench for the homomorphic filter gain generator: clock, reset, register
// settings, coordinate stimulus and the verdict. Depends on hmf_pkg, hmf_checker and the generator top.
module homomorphic_filter_mask_gen_tb import hmf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  hmf_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  hmf_out_t    out_data;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_wdata = '0;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          hold_off = 0;

  homomorphic_filter_mask_gen dut (.*);
  hmf_checker checker_inst (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall per transaction, plus long hold-offs on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1;
      end else if (out_valid && !out_stall) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          out_stall <= 1;
          repeat (gap) @(posedge clk);
          out_stall <= 0;
        end
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic write_reg(hmf_reg_t idx, logic [10:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic send_coord(logic [9:0] row, logic [9:0] col, bit with_gaps);
    int gap;
    gap = with_gaps ? $urandom_range(0, 19) : 0;
    if (with_gaps && $urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= {row, col};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_all(logic [10:0] gh, logic [10:0] gl, logic [10:0] sl,
                         logic [10:0] d0, logic [10:0] rows, logic [10:0] cols);
    write_reg(REG_GAIN_HIGH, gh);
    write_reg(REG_GAIN_LOW, gl);
    write_reg(REG_SHARPNESS, sl);
    write_reg(REG_CUTOFF, d0);
    write_reg(REG_PLANE_ROWS, rows);
    write_reg(REG_PLANE_COLS, cols);
    write_reg(hmf_reg_t'(3'd7), 11'h7ff);
    cfg_we <= 0;
  endtask

  task automatic random_coords(int count, int rows, int cols);
    logic [9:0] r, c;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: begin r = 10'($urandom); c = 10'($urandom); end
        default: begin
          r = 10'(rows / 2 + $urandom_range(0, 24) - 12);
          c = 10'(cols / 2 + $urandom_range(0, 24) - 12);
        end
      endcase
      send_coord(r, c, 1);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset values: zero cutoff, center at 512.
    send_coord(10'd512, 10'd512, 0);
    send_coord(10'd0, 10'd0, 0);
    drain();

    set_all(11'd100, 11'd0, 11'd100, 11'd1, 11'd1024, 11'd1024);
    send_coord(10'd512, 10'd512, 0);
    send_coord(10'd512, 10'd513, 0);
    send_coord(10'd1023, 10'd1023, 0);
    send_coord(10'd0, 10'd0, 0);
    drain();

    set_all(11'd0, 11'd100, 11'd1, 11'd100, 11'd2047, 11'd0);
    send_coord(10'd512, 10'd0, 0);
    send_coord(10'd500, 10'd3, 0);
    send_coord(10'd1023, 10'd1023, 0);
    send_coord(10'd0, 10'd682, 0);
    drain();

    set_all(11'd127, 11'd127, 11'd127, 11'd127, 11'd1, 11'd1);
    send_coord(10'd0, 10'd0, 0);
    send_coord(10'd100, 10'd100, 0);
    send_coord(10'h2aa, 10'h155, 0);
    send_coord(10'h155, 10'h2aa, 0);
    drain();

    set_all(11'd80, 11'd20, 11'd7, 11'd0, 11'd64, 11'd33);
    send_coord(10'd32, 10'd16, 0);
    send_coord(10'd33, 10'd16, 0);
    drain();

    // Back-pressure: stall the output while the sender keeps offering.
    set_all(11'd90, 11'd10, 11'd5, 11'd30, 11'd256, 11'd256);
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 150; i++) send_coord(10'($urandom), 10'($urandom), 0);
    join
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      int rows, cols;
      rows = $urandom_range(1, 1024);
      cols = $urandom_range(1, 1024);
      set_all(11'($urandom_range(0, 127)), 11'($urandom_range(0, 127)),
              11'($urandom_range(0, 127)),
              11'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 127)),
              11'(rows), 11'(cols));
      random_coords(90, rows, cols);
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/hmf_pkg.sv
rtl/hmf_div.sv
rtl/hmf_exp.sv
rtl/homomorphic_filter_mask_gen.sv
tb/hmf_checker.sv
tb/homomorphic_filter_mask_gen_tb.sv
